FILE: rtl/rec_pkg.sv
// package for the rotary encoder counter: widths, codes, fsm states and
// controller/datapath command and status structs; no dependencies
`default_nettype none

package rec_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  localparam logic [1:0] REG_WRAP_LIMIT = 2'd0;
  localparam logic [1:0] REG_PULSE_DIVIDER = 2'd1;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_CW = 2'd1;
  localparam logic [1:0] DIR_CCW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT
  } rec_state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } rec_cmd_t;

  typedef struct packed {
    logic div_done;
  } rec_status_t;

endpackage

`default_nettype wire

FILE: rtl/rotary_encoder_counter.sv
// rotary encoder counter top level: controller plus datapath, depends on rec_pkg
// an input transaction is accepted only when idle; it then runs the eight-step
// restoring divider for pulses and waits while the previous output is stalled;
// no new transaction is accepted until its result is loaded for output
// reset: synchronous active-high rst clears count, edge history and state, and
// sets config (wrap_limit 20, pulse_divider 1)
`default_nettype none

module rotary_encoder_counter import rec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        clk_level,
  input  wire logic        dt_level,
  input  wire logic        switch_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       direction,
  output logic             moving,
  output logic             pressed,
  output logic [7:0]       pulses,
  output logic [15:0]      position
);

  rec_cmd_t    cmd;
  rec_status_t status;

  rec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rec_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .clk_level    (clk_level),
    .dt_level     (dt_level),
    .switch_level (switch_level),
    .cmd          (cmd),
    .status       (status),
    .direction    (direction),
    .moving       (moving),
    .pressed      (pressed),
    .pulses       (pulses),
    .position     (position)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> in_stall)
    else $error("block not busy after input transaction");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

  a_moving_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (moving == (direction != DIR_IDLE)) && (direction != 2'd3))
    else $error("moving and direction disagree");
`endif

endmodule

`default_nettype wire

FILE: rtl/rec_ctrl.sv
// controller fsm for the rotary encoder counter
// depends on rec_pkg
`default_nettype none

module rec_ctrl import rec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire rec_status_t status,
  output rec_cmd_t         cmd
);

  rec_state_t state;
  rec_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rec_datapath.sv
// datapath for the rotary encoder counter: config registers, count update,
// restoring divider for pulses and the output register; depends on rec_pkg
`default_nettype none

module rec_datapath import rec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        clk_level,
  input  wire logic        dt_level,
  input  wire logic        switch_level,
  input  wire rec_cmd_t    cmd,
  output rec_status_t      status,
  output logic [1:0]       direction,
  output logic             moving,
  output logic             pressed,
  output logic [7:0]       pulses,
  output logic [15:0]      position
);

  logic [15:0]           wrap_limit;
  logic [7:0]            pulse_divider;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  last_clock;
  logic                  last_switch;
  logic [1:0]            dir_item;
  logic [1:0]            dir_next;
  logic                  pressed_item;
  logic                  switch_active;
  logic [7:0]            quot;
  logic [7:0]            rem;
  logic [8:0]            rem_shift;
  logic [STEP_W-1:0]     step;

  logic [EXT_W-1:0] lim;
  logic [EXT_W-1:0] wrap_ext;
  logic [EXT_W-1:0] mask_ext;
  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W-1:0] cnt_dec;
  logic [EXT_W:0]   cnt_inc;
  logic [EXT_W-1:0] cnt_new;
  logic [EXT_W-1:0] next_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit    <= 16'd20;
      pulse_divider <= 8'd1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_WRAP_LIMIT: begin
          wrap_limit <= cfg_data;
        end
        REG_PULSE_DIVIDER: begin
          pulse_divider <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // next count on a rising encoder clock edge
  always_comb begin
    switch_active = ~switch_level;
    wrap_ext = EXT_W'(wrap_limit);
    mask_ext = EXT_W'({COUNT_BITS{1'b1}});
    lim      = (wrap_ext > mask_ext) ? mask_ext : wrap_ext;
    cnt_ext  = EXT_W'(count);
    cnt_dec  = cnt_ext - EXT_W'(1);
    cnt_inc  = {1'b0, cnt_ext} + (EXT_W + 1)'(1);
    cnt_new  = cnt_ext;
    dir_next = DIR_IDLE;
    if (clk_level && !last_clock) begin
      if (dt_level != clk_level) begin
        dir_next = DIR_CW;
        if (cnt_ext == '0) begin
          cnt_new = lim;
        end else if (cnt_dec > lim) begin
          cnt_new = '0;
        end else begin
          cnt_new = cnt_dec;
        end
      end else begin
        dir_next = DIR_CCW;
        if (cnt_inc > {1'b0, lim}) begin
          cnt_new = '0;
        end else begin
          cnt_new = cnt_inc[EXT_W-1:0];
        end
      end
    end
    count_next = cnt_new[COUNT_BITS-1:0];
    next_ext   = EXT_W'(count_next);
    rem_shift  = {rem, quot[7]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      last_clock  <= 1'b0;
      last_switch <= 1'b0;
    end else if (cmd.accept) begin
      count       <= count_next;
      last_clock  <= clk_level;
      last_switch <= switch_active;
    end
  end

  // restoring division of the low count byte, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dir_item     <= dir_next;
      pressed_item <= switch_active & ~last_switch;
      quot         <= next_ext[7:0];
      rem          <= 8'd0;
      step         <= '0;
    end else if (cmd.div_step) begin
      step <= step + STEP_W'(1);
      if (rem_shift >= {1'b0, pulse_divider}) begin
        rem  <= 8'(rem_shift - {1'b0, pulse_divider});
        quot <= {quot[6:0], 1'b1};
      end else begin
        rem  <= rem_shift[7:0];
        quot <= {quot[6:0], 1'b0};
      end
    end
  end

  assign status.div_done = (step == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      direction <= dir_item;
      moving    <= (dir_item != DIR_IDLE);
      pressed   <= pressed_item;
      pulses    <= quot;
      position  <= cnt_ext[15:0];
    end
  end

endmodule

`default_nettype wire

FILE: test/encoder_count_checker.sv
// encoder count checker: follows config writes and both transaction channels, predicts
// each reading of the rotary encoder counter and compares it field by field
// depends on rec_pkg for register indexes and direction codes
module encoder_count_checker import rec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        clk_level,
  input  logic        dt_level,
  input  logic        switch_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  direction,
  input  logic        moving,
  input  logic        pressed,
  input  logic [7:0]  pulses,
  input  logic [15:0] position,
  output int          readings_due,
  output int          mismatches
);

  typedef struct packed {
    logic [1:0]  direction;
    logic        moving;
    logic        pressed;
    logic [7:0]  pulses;
    logic [15:0] position;
  } encoder_reading_t;

  logic [15:0] limit_reg;
  logic [7:0]  divider_reg;
  logic [15:0] count;
  logic        clk_prev;
  logic        switch_was_active;
  encoder_reading_t due_readings[$];

  function automatic encoder_reading_t step_encoder(input logic c, input logic d,
                                                    input logic s);
    encoder_reading_t r;
    logic active;
    int unsigned cur;
    int unsigned lim;
    int unsigned stepped;
    active = ~s;
    cur = 32'(count);
    lim = 32'(limit_reg);
    stepped = cur;
    r.direction = DIR_IDLE;
    if (c && !clk_prev) begin
      if (d != c) begin
        r.direction = DIR_CW;
        if (cur == 0) stepped = lim;
        else if (cur - 1 > lim) stepped = 0;
        else stepped = cur - 1;
      end else begin
        r.direction = DIR_CCW;
        if (cur + 1 > lim) stepped = 0;
        else stepped = cur + 1;
      end
      count = stepped[15:0];
    end
    r.moving = (r.direction != DIR_IDLE);
    r.pressed = active && !switch_was_active;
    clk_prev = c;
    switch_was_active = active;
    r.pulses = count[7:0] / divider_reg;
    r.position = count;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    encoder_reading_t want;
    if (rst) begin
      limit_reg = 16'd20;
      divider_reg = 8'd1;
      count = '0;
      clk_prev = 1'b0;
      switch_was_active = 1'b0;
      due_readings.delete();
      mismatches = 0;
      readings_due <= 0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_WRAP_LIMIT) begin
          limit_reg = cfg_data;
        end else if (cfg_index == REG_PULSE_DIVIDER) begin
          divider_reg = (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        end
      end
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          $display("%0t: reading with none expected, position %0d", $time, position);
          mismatches++;
        end else begin
          want = due_readings.pop_front();
          check_field("direction", 32'(want.direction), 32'(direction));
          check_field("moving", 32'(want.moving), 32'(moving));
          check_field("pressed", 32'(want.pressed), 32'(pressed));
          check_field("pulses", 32'(want.pulses), 32'(pulses));
          check_field("position", 32'(want.position), 32'(position));
        end
      end
      if (in_valid && !in_stall) begin
        due_readings.push_back(step_encoder(clk_level, dt_level, switch_level));
      end
      readings_due <= due_readings.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// top of the rotary encoder counter testbench: clock, reset, config writes,
// directed and random encoder samples, random output stalls and the verdict
// depends on rec_pkg, rotary_encoder_counter and encoder_count_checker
module tb_top;
  import rec_pkg::*;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = REG_WRAP_LIMIT;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        clk_level = 1'b0;
  logic        dt_level = 1'b0;
  logic        switch_level = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  direction;
  logic        moving;
  logic        pressed;
  logic [7:0]  pulses;
  logic [15:0] position;
  int          readings_due;
  int          mismatches;
  bit          tail_phase = 1'b0;

  rotary_encoder_counter dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .clk_level(clk_level),
    .dt_level(dt_level),
    .switch_level(switch_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .direction(direction),
    .moving(moving),
    .pressed(pressed),
    .pulses(pulses),
    .position(position)
  );

  encoder_count_checker reading_check (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .clk_level(clk_level),
    .dt_level(dt_level),
    .switch_level(switch_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .direction(direction),
    .moving(moving),
    .pressed(pressed),
    .pulses(pulses),
    .position(position),
    .readings_due(readings_due),
    .mismatches(mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!tail_phase && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  task automatic wait_readings_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_due != 0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    wait_readings_done();
    cfg_write_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_sample(input bit c, input bit d, input bit s);
    if (!tail_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    clk_level <= c;
    dt_level <= d;
    switch_level <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly clean clock toggling with random data, some noise samples
  task automatic send_random_samples(input int n);
    bit c;
    bit d;
    bit s;
    c = 1'b0;
    s = 1'b1;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        c = 1'($urandom);
        d = 1'($urandom);
        s = 1'($urandom);
      end else begin
        c = ~c;
        d = 1'($urandom);
        if ($urandom_range(0, 7) == 0) s = ~s;
      end
      send_sample(c, d, s);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset limit and divider
    send_sample(1, 1, 1);
    send_sample(0, 0, 1);
    send_sample(1, 0, 0);
    send_sample(1, 0, 0);
    send_sample(0, 1, 1);
    send_sample(1, 0, 1);
    send_sample(0, 0, 1);
    send_sample(1, 1, 0);
    send_sample(1, 1, 1);

    // full range limit, zero divider stores one, writes to unused indexes
    write_reg(REG_WRAP_LIMIT, 16'hFFFF);
    write_reg(REG_PULSE_DIVIDER, 16'h0000);
    write_reg(REG_SPARE_2, 16'h5555);
    write_reg(REG_SPARE_3, 16'hAAAA);
    send_sample(0, 0, 1);
    send_sample(1, 0, 1);
    send_sample(0, 1, 1);
    send_sample(1, 1, 1);

    // count left above a lowered limit, stepped down and then up
    write_reg(REG_WRAP_LIMIT, 16'd300);
    write_reg(REG_PULSE_DIVIDER, 16'h0007);
    send_sample(0, 0, 1);
    send_sample(1, 0, 1);
    write_reg(REG_WRAP_LIMIT, 16'd5);
    send_sample(0, 0, 1);
    send_sample(1, 0, 1);
    write_reg(REG_WRAP_LIMIT, 16'd300);
    send_sample(0, 0, 1);
    send_sample(1, 0, 1);
    write_reg(REG_WRAP_LIMIT, 16'd5);
    send_sample(0, 1, 1);
    send_sample(1, 1, 1);
    write_reg(REG_PULSE_DIVIDER, 16'h00FF);
    send_sample(0, 0, 1);
    send_sample(1, 0, 1);

    for (int p = 0; p < 8; p++) begin
      if (p == 7) tail_phase = 1'b1;
      if (p == 0) begin
        write_reg(REG_WRAP_LIMIT, 16'd0);
        write_reg(REG_PULSE_DIVIDER, 16'h0001);
      end else if (p == 1) begin
        write_reg(REG_WRAP_LIMIT, 16'hFFFF);
        write_reg(REG_PULSE_DIVIDER, 16'hFF00);
      end else begin
        if ($urandom_range(0, 2) == 0)
          write_reg(REG_WRAP_LIMIT, 16'($urandom_range(0, 65535)));
        else write_reg(REG_WRAP_LIMIT, 16'($urandom_range(0, 40)));
        write_reg(REG_PULSE_DIVIDER, 16'($urandom_range(0, 65535)));
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  16'($urandom_range(0, 65535)));
      end
      send_random_samples(50);
    end

    wait_readings_done();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rec_pkg.sv
rtl/rec_ctrl.sv
rtl/rec_datapath.sv
rtl/rotary_encoder_counter.sv
test/encoder_count_checker.sv
test/tb_top.sv
